/* hw/rtl/tpl_pkg.sv */
package tpl_pkg;

  localparam int TxnSlotsDef    = 16;
  localparam int LockEntriesDef = 64;
  localparam int KeyBitsDef     = 32;
  localparam logic [6:0] RetryReset = 7'd100;

  localparam logic [2:0] CmdBegin  = 3'd0;
  localparam logic [2:0] CmdLockSh = 3'd1;
  localparam logic [2:0] CmdLockEx = 3'd2;
  localparam logic [2:0] CmdUnlock = 3'd3;
  localparam logic [2:0] CmdEnd    = 3'd4;

  localparam logic [2:0] StDone    = 3'd0;
  localparam logic [2:0] StBlocked = 3'd1;
  localparam logic [2:0] StRetry   = 3'd2;
  localparam logic [2:0] StNotHeld = 3'd3;
  localparam logic [2:0] StFull    = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  txn_id;
    logic [31:0] record_key;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] status;
    logic       deadlock_found;
    logic       victim_valid;
    logic [3:0] victim_slot;
  } rsp_t;

  // Commands from the sequencer to the waits-for graph unit.
  typedef struct packed {
    logic set_live;
    logic clr_slot;
    logic add_edges;
    logic reach_start;
  } wfg_ctl_t;

endpackage

/* hw/rtl/tpl_ram.sv */
module tpl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/tpl_wfg.sv */
module tpl_wfg #(
  parameter int TxnSlots = tpl_pkg::TxnSlotsDef,
  parameter int SlotW    = $clog2(TxnSlots)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tpl_pkg::wfg_ctl_t    ctl_i,
  input  logic [SlotW-1:0]     slot_i,
  input  logic [TxnSlots-1:0]  edges_i,
  output logic                 done_o,
  output logic                 cycle_o,
  output logic                 cand_o,
  output logic [SlotW-1:0]     victim_o
);

  logic [TxnSlots-1:0] rows_q [TxnSlots];
  logic [TxnSlots-1:0] live_q;
  logic [TxnSlots-1:0] r_q, r_d, cand;
  logic                run_q;
  logic [SlotW-1:0]    rs_q;

  // One expansion step of the reachable set per cycle.
  always_comb begin
    r_d = r_q;
    for (int j = 0; j < TxnSlots; j++) begin
      if (r_q[j]) begin
        r_d = r_d | rows_q[j];
      end
    end
  end

  assign done_o  = run_q && (r_d == r_q);
  assign cycle_o = r_q[rs_q];
  assign cand    = (r_q | (TxnSlots'(1) << rs_q)) & live_q;
  assign cand_o  = |cand;

  always_comb begin
    victim_o = '0;
    for (int j = 0; j < TxnSlots; j++) begin
      if (cand[j]) begin
        victim_o = SlotW'(j);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TxnSlots; j++) begin
        rows_q[j] <= '0;
      end
      live_q <= '0;
      run_q  <= 1'b0;
      r_q    <= '0;
      rs_q   <= '0;
    end else begin
      if (ctl_i.add_edges) begin
        rows_q[slot_i] <= rows_q[slot_i] | edges_i;
      end
      if (ctl_i.set_live) begin
        live_q[slot_i] <= 1'b1;
      end
      if (ctl_i.clr_slot) begin
        live_q[slot_i] <= 1'b0;
        for (int j = 0; j < TxnSlots; j++) begin
          if (j == int'(slot_i)) begin
            rows_q[j] <= '0;
          end else begin
            rows_q[j][slot_i] <= 1'b0;
          end
        end
      end
      if (ctl_i.reach_start) begin
        r_q   <= rows_q[slot_i];
        rs_q  <= slot_i;
        run_q <= 1'b1;
      end else if (run_q) begin
        r_q <= r_d;
        if (r_d == r_q) begin
          run_q <= 1'b0;
        end
      end
    end
  end

endmodule

/* hw/rtl/two_phase_lock_table_with_deadlock_check_core.sv */
// Channel   Direction  Handshake                 Payload
// command   in         start_i, busy_o           req_i  (tpl_pkg::req_t)
// result    out        done_o (one-cycle strobe)  rsp_o  (tpl_pkg::rsp_t)
// config    in         APB psel/penable/pwrite   max_retries at byte address 0
//
// After reset the block clears the table, one entry per cycle, and stays busy until
// every entry is cleared. Begin and invalid commands answer in the next cycle.
// Unlock and each lock attempt scan the whole table; a blocked attempt adds the
// reachability steps of the waits-for graph, a read to recheck the entry and,
// per victim or End, a release sweep over the table.
// The result beat is shown for one cycle; the receiver cannot stall it.
module two_phase_lock_table_with_deadlock_check_core #(
  parameter int TXN_SLOTS    = tpl_pkg::TxnSlotsDef,
  parameter int LOCK_ENTRIES = tpl_pkg::LockEntriesDef,
  parameter int KEY_BITS     = tpl_pkg::KeyBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  tpl_pkg::req_t req_i,
  output logic          done_o,
  output tpl_pkg::rsp_t rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int SW = $clog2(TXN_SLOTS);
  localparam int IW = $clog2(LOCK_ENTRIES);
  localparam int CW = IW + 1;
  // Entry word: used, owner valid, owner slot, sharer mask, key.
  localparam int EW    = 2 + SW + TXN_SLOTS + KEY_BITS;
  localparam int SmLo  = KEY_BITS;
  localparam int OsLo  = KEY_BITS + TXN_SLOTS;

  localparam logic [3:0] ST_CLEAR      = 4'd0;
  localparam logic [3:0] ST_IDLE       = 4'd1;
  localparam logic [3:0] ST_FIND       = 4'd2;
  localparam logic [3:0] ST_REACH_GO   = 4'd3;
  localparam logic [3:0] ST_REACH_WAIT = 4'd4;
  localparam logic [3:0] ST_WALK       = 4'd5;
  localparam logic [3:0] ST_CHK_RD     = 4'd6;
  localparam logic [3:0] ST_CHK        = 4'd7;

  logic [3:0]          state_q, state_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [7:0]          depth_q, depth_d;
  logic                dl_q, dl_d, vv_q, vv_d;
  logic [SW-1:0]       vt_q, vt_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                pv_q, pv_d;
  logic [IW-1:0]       paddr_q, paddr_d;
  logic                found_q, found_d, free_q, free_d;
  logic [IW-1:0]       fidx_q, fidx_d, free_idx_q, free_idx_d, cur_idx_q, cur_idx_d;
  logic [EW-1:0]       fdata_q, fdata_d;
  logic                walk_end_q, walk_end_d;
  logic [SW-1:0]       walk_slot_q, walk_slot_d;
  logic                done_q;
  tpl_pkg::rsp_t       rsp_q;
  logic [6:0]          maxr_q;

  // Table memory port.
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  tpl_ram #(.Width(EW), .Depth(LOCK_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Waits-for graph with live mask and reachability engine.
  tpl_pkg::wfg_ctl_t  wctl;
  logic [SW-1:0]      wslot;
  logic [TXN_SLOTS-1:0] wedges;
  logic               w_done, w_cycle, w_cand;
  logic [SW-1:0]      w_victim;

  tpl_wfg #(.TxnSlots(TXN_SLOTS), .SlotW(SW)) u_wfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (wctl),
    .slot_i   (wslot),
    .edges_i  (wedges),
    .done_o   (w_done),
    .cycle_o  (w_cycle),
    .cand_o   (w_cand),
    .victim_o (w_victim)
  );

  // Configuration port. Register 0 is the retry limit; pready is tied high.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {25'd0, maxr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxr_q <= tpl_pkg::RetryReset;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      maxr_q <= pwdata[6:0];
    end
  end

  // Fields of the entry word coming back from the table.
  logic                 r_used, r_ov;
  logic [SW-1:0]        r_os;
  logic [TXN_SLOTS-1:0] r_sm;
  logic [KEY_BITS-1:0]  r_key;
  assign r_used = ram_rdata[EW-1];
  assign r_ov   = ram_rdata[EW-2];
  assign r_os   = ram_rdata[OsLo +: SW];
  assign r_sm   = ram_rdata[SmLo +: TXN_SLOTS];
  assign r_key  = ram_rdata[KEY_BITS-1:0];

  // Sequencer.
  logic                 issue, scan_end, emit, e_ok, is_shared;
  logic [2:0]           e_st;
  logic [TXN_SLOTS-1:0] bit_t, bit_w, others, edges;
  logic                 d_ov, nov, grant, own, shr, w_ov;
  logic [SW-1:0]        d_os, nos;
  logic [TXN_SLOTS-1:0] d_sm, nsm, w_sm;
  logic [EW-1:0]        dsel;
  logic [IW-1:0]        idx;
  logic                 freed;

  assign issue     = cnt_q < CW'(LOCK_ENTRIES);
  assign scan_end  = !pv_q && !issue;
  assign is_shared = (cmd_q == tpl_pkg::CmdLockSh);
  assign bit_t     = TXN_SLOTS'(1) << slot_q;
  assign bit_w     = TXN_SLOTS'(1) << walk_slot_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    key_d       = key_q;
    depth_d     = depth_q;
    dl_d        = dl_q;
    vv_d        = vv_q;
    vt_d        = vt_q;
    cnt_d       = cnt_q;
    pv_d        = pv_q;
    paddr_d     = paddr_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    fdata_d     = fdata_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    cur_idx_d   = cur_idx_q;
    walk_end_d  = walk_end_q;
    walk_slot_d = walk_slot_q;
    ram_we      = 1'b0;
    ram_waddr   = paddr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = cnt_q[IW-1:0];
    wctl        = '0;
    wslot       = slot_q;
    wedges      = '0;
    emit        = 1'b0;
    e_ok        = 1'b0;
    e_st        = tpl_pkg::StDone;
    // Decision terms for the entry picked by a lock request.
    idx    = found_q ? fidx_q : free_idx_q;
    dsel   = found_q ? fdata_q : {1'b1, 1'b0, SW'(0), TXN_SLOTS'(0), key_q};
    d_ov   = dsel[EW-2];
    d_os   = dsel[OsLo +: SW];
    d_sm   = dsel[SmLo +: TXN_SLOTS];
    others = d_sm & ~bit_t;
    grant  = 1'b0;
    nov    = d_ov;
    nos    = d_os;
    nsm    = d_sm;
    edges  = '0;
    own    = found_q && fdata_q[EW-2] && (fdata_q[OsLo +: SW] == slot_q);
    shr    = found_q && |(fdata_q[SmLo +: TXN_SLOTS] & bit_t);
    w_ov   = r_ov && (r_os != walk_slot_q);
    w_sm   = r_sm & ~bit_w;
    freed  = !r_used || (!r_ov && (is_shared || (r_sm == '0)));

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IW-1:0];
        cnt_d     = cnt_q + CW'(1);
        if (cnt_q[IW-1:0] == IW'(LOCK_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d   = req_i.cmd;
          slot_d  = SW'(req_i.txn_id);
          key_d   = KEY_BITS'(req_i.record_key);
          depth_d = '0;
          dl_d    = 1'b0;
          vv_d    = 1'b0;
          vt_d    = '0;
          cnt_d   = '0;
          pv_d    = 1'b0;
          found_d = 1'b0;
          free_d  = 1'b0;
          wslot   = SW'(req_i.txn_id);
          if (req_i.cmd > tpl_pkg::CmdEnd) begin
            emit = 1'b1;
          end else if (int'(req_i.txn_id) >= TXN_SLOTS) begin
            emit = 1'b1;
            e_st = tpl_pkg::StNotHeld;
          end else begin
            case (req_i.cmd)
              tpl_pkg::CmdBegin: begin
                wctl.set_live = 1'b1;
                emit          = 1'b1;
                e_ok          = 1'b1;
              end
              tpl_pkg::CmdEnd: begin
                wctl.clr_slot = 1'b1;
                walk_slot_d   = SW'(req_i.txn_id);
                walk_end_d    = 1'b1;
                state_d       = ST_WALK;
              end
              default: begin
                state_d = ST_FIND;
              end
            endcase
          end
        end
      end
      ST_FIND: begin
        ram_re  = issue;
        pv_d    = issue;
        paddr_d = cnt_q[IW-1:0];
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pv_q) begin
          if (r_used && (r_key == key_q) && !found_q) begin
            found_d = 1'b1;
            fidx_d  = paddr_q;
            fdata_d = ram_rdata;
          end
          if (!r_used && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = paddr_q;
          end
        end
        if (scan_end) begin
          if (cmd_q == tpl_pkg::CmdUnlock) begin
            emit = 1'b1;
            if (own || shr) begin
              e_ok = 1'b1;
              nov  = fdata_q[EW-2] && !own;
              nsm  = own ? fdata_q[SmLo +: TXN_SLOTS] : (fdata_q[SmLo +: TXN_SLOTS] & ~bit_t);
              ram_we    = 1'b1;
              ram_waddr = fidx_q;
              ram_wdata = {nov || (nsm != '0), nov, fdata_q[OsLo +: SW], nsm,
                           fdata_q[KEY_BITS-1:0]};
            end else begin
              e_st = tpl_pkg::StNotHeld;
            end
          end else if (!found_q && !free_q) begin
            emit = 1'b1;
            e_st = tpl_pkg::StFull;
          end else begin
            if (is_shared) begin
              grant = !d_ov || (d_os == slot_q);
              if (grant) begin
                nsm = d_sm | bit_t;
              end
              edges = TXN_SLOTS'(1) << d_os;
            end else if (d_ov && (d_os == slot_q)) begin
              grant = 1'b1;
            end else if (!d_ov && (others == '0)) begin
              grant = 1'b1;
              nsm   = '0;
              nov   = 1'b1;
              nos   = slot_q;
            end else begin
              edges = (d_ov ? (TXN_SLOTS'(1) << d_os) : TXN_SLOTS'(0)) | others;
            end
            ram_we    = 1'b1;
            ram_waddr = idx;
            ram_wdata = {1'b1, nov, nos, nsm, key_q};
            cur_idx_d = idx;
            if (grant) begin
              emit = 1'b1;
              e_ok = 1'b1;
            end else begin
              wctl.add_edges = 1'b1;
              wedges         = edges;
              state_d        = ST_REACH_GO;
            end
          end
        end
      end
      ST_REACH_GO: begin
        wctl.reach_start = 1'b1;
        state_d          = ST_REACH_WAIT;
      end
      ST_REACH_WAIT: begin
        if (w_done) begin
          if (!w_cycle) begin
            emit = 1'b1;
            e_st = tpl_pkg::StBlocked;
          end else begin
            dl_d = 1'b1;
            if (w_cand) begin
              vv_d          = 1'b1;
              vt_d          = w_victim;
              wctl.clr_slot = 1'b1;
              wslot         = w_victim;
              walk_slot_d   = w_victim;
              walk_end_d    = 1'b0;
              cnt_d         = '0;
              pv_d          = 1'b0;
              state_d       = ST_WALK;
            end else begin
              state_d = ST_CHK_RD;
            end
          end
        end
      end
      ST_WALK: begin
        ram_re  = issue;
        pv_d    = issue;
        paddr_d = cnt_q[IW-1:0];
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pv_q && r_used) begin
          ram_we    = 1'b1;
          ram_waddr = paddr_q;
          ram_wdata = {w_ov || (w_sm != '0), w_ov, r_os, w_sm, r_key};
        end
        if (scan_end) begin
          if (walk_end_q) begin
            emit = 1'b1;
            e_ok = 1'b1;
          end else begin
            state_d = ST_CHK_RD;
          end
        end
      end
      ST_CHK_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_idx_q;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        if (!freed) begin
          emit = 1'b1;
          e_st = tpl_pkg::StBlocked;
        end else begin
          depth_d = depth_q + 8'd1;
          if (depth_d > {1'b0, maxr_q}) begin
            emit = 1'b1;
            e_st = tpl_pkg::StRetry;
          end else begin
            cnt_d   = '0;
            pv_d    = 1'b0;
            found_d = 1'b0;
            free_d  = 1'b0;
            state_d = ST_FIND;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      done_q  <= emit;
    end
  end

  // Working registers of the current command; they carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    slot_q      <= slot_d;
    key_q       <= key_d;
    depth_q     <= depth_d;
    dl_q        <= dl_d;
    vv_q        <= vv_d;
    vt_q        <= vt_d;
    paddr_q     <= paddr_d;
    found_q     <= found_d;
    fidx_q      <= fidx_d;
    fdata_q     <= fdata_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    cur_idx_q   <= cur_idx_d;
    walk_end_q  <= walk_end_d;
    walk_slot_q <= walk_slot_d;
    if (emit) begin
      rsp_q.ok             <= e_ok;
      rsp_q.status         <= e_st;
      rsp_q.deadlock_found <= dl_d;
      rsp_q.victim_valid   <= vv_d;
      rsp_q.victim_slot    <= vv_d ? 4'(vt_d) : 4'd0;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* hw/rtl/tpl_chk.sv */
module tpl_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input tpl_pkg::req_t req_i,
  input logic          done_o,
  input tpl_pkg::rsp_t rsp_o,
  input logic          pready
);

  // A granted or completed command always reports the done status.
  a_ok_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.ok |-> rsp_o.status == tpl_pkg::StDone)
    else $error("ok result with nonzero status");

  // A victim is only aborted after a deadlock was found.
  a_victim_dl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.victim_valid |-> rsp_o.deadlock_found)
    else $error("victim without deadlock");

  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.victim_valid |-> rsp_o.victim_slot == 4'd0)
    else $error("victim id without victim");

  // Unknown commands are answered in the next cycle and change nothing.
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.cmd > tpl_pkg::CmdEnd) |=>
      done_o && !rsp_o.ok && (rsp_o.status == tpl_pkg::StDone) && !busy_o)
    else $error("unknown command not answered at once");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind two_phase_lock_table_with_deadlock_check_core tpl_chk u_tpl_chk (.*);

/* sim/two_phase_lock_table_with_deadlock_check_core_tb.sv */
module two_phase_lock_table_with_deadlock_check_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots      = 16;
  localparam int Entries    = 64;
  // The slowest request walks the table several times per attempt and may
  // abort up to every slot once. This bound leaves a wide margin over the
  // whole run.
  localparam int CycleLimit = 40_000_000;
  localparam int SettleCycles = 300;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic          busy_o;
  tpl_pkg::req_t req_i = '0;
  logic          done_o;
  tpl_pkg::rsp_t rsp_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  two_phase_lock_table_with_deadlock_check_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Lock manager shadow. It mirrors the lock table, the waits-for matrix and
  // the live mask, and is advanced once per accepted command beat.
  // ---------------------------------------------------------------------------
  logic [31:0] key_tab [Entries];
  bit          used    [Entries];
  bit          own_v   [Entries];
  logic [3:0]  own_s   [Entries];
  logic [15:0] sharers [Entries];
  logic [15:0] waits_on [Slots];
  logic [15:0] live;
  logic [6:0]  retry_max;

  tpl_pkg::rsp_t pending_rsp [$];
  int   errors = 0;
  int   cycles = 0;
  int   idle_pct = 0;

  function automatic void shadow_reset();
    for (int i = 0; i < Entries; i++) begin
      key_tab[i] = '0;
      used[i] = 1'b0;
      own_v[i] = 1'b0;
      own_s[i] = '0;
      sharers[i] = '0;
    end
    for (int j = 0; j < Slots; j++) waits_on[j] = '0;
    live = '0;
    retry_max = tpl_pkg::RetryReset;
  endfunction

  function automatic int lookup(logic [31:0] key);
    for (int i = 0; i < Entries; i++)
      if (used[i] && key_tab[i] == key) return i;
    return -1;
  endfunction

  function automatic int claim(logic [31:0] key);
    for (int i = 0; i < Entries; i++) begin
      if (!used[i]) begin
        used[i] = 1'b1;
        key_tab[i] = key;
        own_v[i] = 1'b0;
        own_s[i] = '0;
        sharers[i] = '0;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void free_if_idle(int i);
    if (!own_v[i] && sharers[i] == '0) begin
      used[i] = 1'b0;
      own_s[i] = '0;
    end
  endfunction

  // Drops every lock of slot t and its place in the waits-for graph.
  function automatic void retire_slot(logic [3:0] t);
    for (int i = 0; i < Entries; i++) begin
      if (used[i]) begin
        if (own_v[i] && own_s[i] == t) own_v[i] = 1'b0;
        sharers[i][t] = 1'b0;
        free_if_idle(i);
      end
    end
    live[t] = 1'b0;
    waits_on[t] = '0;
    for (int j = 0; j < Slots; j++) waits_on[j][t] = 1'b0;
  endfunction

  // True when t lies on a waits-for cycle; the highest-numbered live slot among t
  // and the slots it reaches is aborted if there is one.
  function automatic bit break_cycle(logic [3:0] t, inout bit vv, inout logic [3:0] vt);
    logic [15:0] reach;
    logic [15:0] last;
    logic [15:0] cand;
    reach = waits_on[t];
    do begin
      last = reach;
      for (int j = 0; j < Slots; j++)
        if (reach[j]) reach |= waits_on[j];
    end while (reach != last);
    if (!reach[t]) return 1'b0;
    cand = (reach | (16'd1 << t)) & live;
    if (cand != '0) begin
      for (int j = 0; j < Slots; j++)
        if (cand[j]) vt = 4'(j);
      retire_slot(vt);
      vv = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic tpl_pkg::rsp_t lock_outcome(tpl_pkg::req_t r);
    tpl_pkg::rsp_t o;
    int            idx;
    bit            shared;
    bit            vv;
    logic [3:0]    vt;
    logic [15:0]   others;
    logic [3:0]    t;
    o = '0;
    vv = 1'b0;
    vt = '0;
    t = r.txn_id;
    shared = (r.cmd == tpl_pkg::CmdLockSh);
    for (int depth = 0; ; depth++) begin
      if (depth > int'(retry_max)) begin
        o.status = tpl_pkg::StRetry;
        break;
      end
      idx = lookup(r.record_key);
      if (idx < 0) idx = claim(r.record_key);
      if (idx < 0) begin
        o.status = tpl_pkg::StFull;
        break;
      end
      if (shared) begin
        if (!own_v[idx] || own_s[idx] == t) begin
          sharers[idx][t] = 1'b1;
          o.ok = 1'b1;
          break;
        end
        waits_on[t][own_s[idx]] = 1'b1;
      end else begin
        others = sharers[idx] & ~(16'd1 << t);
        if (own_v[idx] && own_s[idx] == t) begin
          o.ok = 1'b1;
          break;
        end
        if (!own_v[idx] && others == '0) begin
          sharers[idx] = '0;
          own_v[idx] = 1'b1;
          own_s[idx] = t;
          o.ok = 1'b1;
          break;
        end
        if (own_v[idx]) waits_on[t][own_s[idx]] = 1'b1;
        waits_on[t] |= others;
      end
      if (!break_cycle(t, vv, vt)) begin
        o.status = tpl_pkg::StBlocked;
        break;
      end
      o.deadlock_found = 1'b1;
      idx = lookup(r.record_key);
      if (idx >= 0 && (own_v[idx] || (!shared && sharers[idx] != '0))) begin
        o.status = tpl_pkg::StBlocked;
        break;
      end
    end
    o.victim_valid = vv;
    o.victim_slot = vv ? vt : 4'd0;
    return o;
  endfunction

  function automatic tpl_pkg::rsp_t command_outcome(tpl_pkg::req_t r);
    tpl_pkg::rsp_t o;
    int            idx;
    o = '0;
    case (r.cmd)
      tpl_pkg::CmdBegin: begin
        live[r.txn_id] = 1'b1;
        o.ok = 1'b1;
      end
      tpl_pkg::CmdEnd: begin
        retire_slot(r.txn_id);
        o.ok = 1'b1;
      end
      tpl_pkg::CmdUnlock: begin
        idx = lookup(r.record_key);
        o.status = tpl_pkg::StNotHeld;
        if (idx >= 0) begin
          // An owner that also shares gives up only the exclusive hold.
          if (own_v[idx] && own_s[idx] == r.txn_id) begin
            own_v[idx] = 1'b0;
            o.ok = 1'b1;
          end else if (sharers[idx][r.txn_id]) begin
            sharers[idx][r.txn_id] = 1'b0;
            o.ok = 1'b1;
          end
          if (o.ok) begin
            o.status = tpl_pkg::StDone;
            free_if_idle(idx);
          end
        end
      end
      tpl_pkg::CmdLockSh, tpl_pkg::CmdLockEx: o = lock_outcome(r);
      default: o = '0;  // Unknown commands are ignored.
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. Every done strobe must match the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
                               cycles);
  endtask

  always @(posedge clk_i) begin
    tpl_pkg::rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected result beat", 32'(rsp_o), 32'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.ok !== want.ok) report("ok", 32'(rsp_o.ok), 32'(want.ok));
        if (rsp_o.status !== want.status)
          report("status", 32'(rsp_o.status), 32'(want.status));
        if (rsp_o.deadlock_found !== want.deadlock_found)
          report("deadlock_found", 32'(rsp_o.deadlock_found), 32'(want.deadlock_found));
        if (rsp_o.victim_valid !== want.victim_valid)
          report("victim_valid", 32'(rsp_o.victim_valid), 32'(want.victim_valid));
        if (rsp_o.victim_slot !== want.victim_slot)
          report("victim_slot", 32'(rsp_o.victim_slot), 32'(want.victim_slot));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL two_phase_lock_table_with_deadlock_check_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Sends one command beat. Start stays high into the next call unless the
  // sender decides to idle, so back-to-back beats never drop start.
  task automatic send_cmd(logic [2:0] cmd, logic [3:0] txn, logic [31:0] key);
    tpl_pkg::req_t r;
    tpl_pkg::rsp_t expected;
    r.cmd = cmd;
    r.txn_id = txn;
    r.record_key = key;
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    expected = command_outcome(r);
    pending_rsp = {pending_rsp, expected};
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  // Lowers start and waits for every predicted beat, then lets the block
  // settle so that a register write finds it idle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_retries(logic [6:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {$urandom()} & 32'hFFFF_FF80 | 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    retry_max = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every command, re-entry, upgrade and the unlock cases.
  task automatic test_commands();
    send_cmd(tpl_pkg::CmdBegin, 4'd0, 32'h0);
    send_cmd(tpl_pkg::CmdBegin, 4'd15, 32'hFFFF_FFFF);
    send_cmd(tpl_pkg::CmdLockEx, 4'd15, 32'hFFFF_FFFF);
    send_cmd(tpl_pkg::CmdLockEx, 4'd15, 32'hFFFF_FFFF);  // re-entry
    send_cmd(tpl_pkg::CmdLockSh, 4'd15, 32'hFFFF_FFFF);  // owner also shares
    send_cmd(tpl_pkg::CmdUnlock, 4'd15, 32'hFFFF_FFFF);  // exclusive hold goes first
    send_cmd(tpl_pkg::CmdUnlock, 4'd15, 32'hFFFF_FFFF);
    send_cmd(tpl_pkg::CmdUnlock, 4'd15, 32'hFFFF_FFFF);  // nothing held any more
    send_cmd(tpl_pkg::CmdLockSh, 4'd0, 32'h0);
    send_cmd(tpl_pkg::CmdLockEx, 4'd0, 32'h0);           // upgrade of a lone sharer
    send_cmd(tpl_pkg::CmdUnlock, 4'd15, 32'h0);          // held by someone else
    send_cmd(tpl_pkg::CmdUnlock, 4'd0, 32'h5A5A_A5A5);   // absent key
    send_cmd(tpl_pkg::CmdLockSh, 4'd15, 32'h0);          // blocked behind slot 0
    send_cmd(tpl_pkg::CmdLockSh, 4'd6, 32'h1234_5678);   // slot that never began
    send_cmd(3'd5, 4'd3, 32'h8000_0001);
    send_cmd(3'd7, 4'd12, 32'h7FFF_FFFE);
    send_cmd(tpl_pkg::CmdEnd, 4'd0, 32'h0);
    send_cmd(tpl_pkg::CmdEnd, 4'd15, 32'h0);
    send_cmd(tpl_pkg::CmdEnd, 4'd6, 32'h0);
    drain();
  endtask

  // Two live slots cross their exclusive locks; the younger one is aborted.
  // Then two slots that never began cross their locks with shared requests and no victim exists.
  task automatic test_deadlock();
    send_cmd(tpl_pkg::CmdBegin, 4'd1, 32'h0);
    send_cmd(tpl_pkg::CmdBegin, 4'd2, 32'h0);
    send_cmd(tpl_pkg::CmdLockEx, 4'd1, 32'hA);
    send_cmd(tpl_pkg::CmdLockEx, 4'd2, 32'hB);
    send_cmd(tpl_pkg::CmdLockEx, 4'd1, 32'hB);
    send_cmd(tpl_pkg::CmdLockEx, 4'd2, 32'hA);
    send_cmd(tpl_pkg::CmdLockEx, 4'd9, 32'hC);
    send_cmd(tpl_pkg::CmdLockEx, 4'd10, 32'hD);
    send_cmd(tpl_pkg::CmdLockSh, 4'd9, 32'hD);
    send_cmd(tpl_pkg::CmdLockSh, 4'd10, 32'hC);
    for (int s = 1; s <= 10; s++) send_cmd(tpl_pkg::CmdEnd, 4'(s), 32'h0);
    drain();
  endtask

  // One slot fills every table entry, so the next new key finds no room.
  task automatic test_table_full();
    send_cmd(tpl_pkg::CmdBegin, 4'd7, 32'h0);
    for (int i = 0; i <= Entries; i++)
      send_cmd(tpl_pkg::CmdLockEx, 4'd7, 32'h1000_0000 + 32'(i));
    send_cmd(tpl_pkg::CmdUnlock, 4'd7, 32'h1000_0003);
    send_cmd(tpl_pkg::CmdLockSh, 4'd7, 32'hDEAD_BEEF);
    send_cmd(tpl_pkg::CmdEnd, 4'd7, 32'h0);
    drain();
  endtask

  // Mostly well-formed traffic over a few busy slots and a small key pool, so
  // that conflicts and cycles are common, with random keys and slots mixed in.
  task automatic test_random_traffic(int beats, int pct, bit pause_often);
    logic [31:0] pool [8];
    logic [2:0]  cmd;
    logic [3:0]  txn;
    logic [31:0] key;
    int          pick;
    idle_pct = pct;
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(99);
      if (pick < 12) cmd = tpl_pkg::CmdBegin;
      else if (pick < 42) cmd = tpl_pkg::CmdLockSh;
      else if (pick < 72) cmd = tpl_pkg::CmdLockEx;
      else if (pick < 85) cmd = tpl_pkg::CmdUnlock;
      else if (pick < 97) cmd = tpl_pkg::CmdEnd;
      else cmd = 3'($urandom_range(5, 7));
      txn = ($urandom_range(9) < 8) ? 4'($urandom_range(5)) : 4'($urandom());
      key = ($urandom_range(9) < 8) ? pool[$urandom_range(7)] : $urandom();
      send_cmd(cmd, txn, key);
      // Pressure: let the pipeline run dry now and then.
      if (pause_often && n % 50 == 49) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (pending_rsp.size() != 0) @(posedge clk_i);
      end
    end
    idle_pct = 0;
    drain();
  endtask

  initial begin
    int unsigned mid;
    shadow_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands();
    test_deadlock();
    write_retries(7'd0);
    test_deadlock();
    test_table_full();

    // Random phases rotate the retry limit through its extremes.
    test_random_traffic(480, 0, 1'b0);
    write_retries(7'd127);
    test_random_traffic(480, 74, 1'b1);
    mid = $urandom_range(1, 126);
    write_retries(7'(mid));
    test_random_traffic(480, 28, 1'b0);
    write_retries(7'd1);
    test_random_traffic(420, 0, 1'b0);

    drain();
    if (errors == 0) begin
      $display("PASS two_phase_lock_table_with_deadlock_check_core");
    end else begin
      $display("FAIL two_phase_lock_table_with_deadlock_check_core");
    end
    $finish;
  end

endmodule
